@@ rtl/fwq_pkg.sv @@
// Package for the futex wait queue table: sizes, status and operation codes,
// and the command record passed from the front end to the back end. No dependencies.
package fwq_pkg;
  localparam int unsigned MaxWaiters = 32;
  localparam int unsigned IdxBits    = $clog2(MaxWaiters);
  localparam int unsigned CntBits    = $clog2(MaxWaiters + 1);
  localparam int unsigned TaskBits   = 8;
  localparam int unsigned ResultLim  = 32;
  localparam int unsigned TotBits    = 6;
  localparam int unsigned QDepth     = 2;

  localparam logic [6:0] OpWait = 7'd0;
  localparam logic [6:0] OpWake = 7'd1;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StInval  = 3'd1,
    StFault  = 3'd2,
    StAgain  = 3'd3,
    StNoMem  = 3'd4,
    StUnsup  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CmdReply = 2'd0,
    CmdWait  = 2'd1,
    CmdWake  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    status_e             status;
    logic [31:0]         addr;
    logic [31:0]         mem_val;
    logic [31:0]         arg;
    logic [TaskBits-1:0] task_id;
    logic [5:0]          limit;
  } cmd_t;
endpackage

@@ rtl/fwq_front.sv @@
// Front end of the futex wait queue table: classifies a request and pushes a
// command into a small queue. Depends on fwq_pkg.
module fwq_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [7:0]               opcode_i,
  input  logic [31:0]              word_address_i,
  input  logic                     access_fault_i,
  input  logic signed [31:0]       memory_value_i,
  input  logic signed [31:0]       argument_i,
  input  logic [7:0]               task_id_i,
  output logic                     busy_o,
  input  logic                     pop_i,
  output logic                     cmd_valid_o,
  output fwq_pkg::cmd_t            cmd_o
);
  import fwq_pkg::*;

  cmd_t                     q_mem [QDepth];
  logic [$clog2(QDepth)-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [$clog2(QDepth):0]   cnt_q, cnt_d;
  cmd_t                     cmd;
  logic [6:0]               op;
  logic                     push;

  assign op = opcode_i[6:0];

  always_comb begin
    cmd         = '0;
    cmd.addr    = word_address_i;
    cmd.mem_val = memory_value_i;
    cmd.arg     = argument_i;
    cmd.task_id = task_id_i[TaskBits-1:0];
    cmd.kind    = CmdReply;
    cmd.status  = StOk;
    if (argument_i > 32'sd31) cmd.limit = 6'(ResultLim);
    else                      cmd.limit = argument_i[5:0];
    priority if (word_address_i == 32'd0 || word_address_i[1:0] != 2'd0) begin
      cmd.status = StInval;
    end else if (access_fault_i) begin
      cmd.status = StFault;
    end else if (op == OpWait) begin
      cmd.kind = CmdWait;
    end else if (op == OpWake) begin
      if (argument_i <= 32'sd0) cmd.kind = CmdReply;
      else                      cmd.kind = CmdWake;
    end else begin
      cmd.status = StUnsup;
    end
  end

  assign busy_o      = (cnt_q == ($clog2(QDepth)+1)'(QDepth));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cmd_valid_o) else $error("pop from empty command queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ($clog2(QDepth)+1)'(QDepth)) else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
`endif
endmodule

@@ rtl/fwq_back.sv @@
// Back end of the futex wait queue table: holds the waiter table and carries
// out wait appends and wake scans. Depends on fwq_pkg.
module fwq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  fwq_pkg::cmd_t       cmd_i,
  output logic                pop_o,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic                task_valid_o,
  output logic [7:0]          woken_task_o,
  output logic [5:0]          woken_total_o,
  output logic                last_o
);
  import fwq_pkg::*;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SRead = 3'b010,
    SScan = 3'b100
  } state_e;

  logic [31:0]         addr_mem [MaxWaiters];
  logic [TaskBits-1:0] task_mem [MaxWaiters];

  state_e              st_q, st_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic [CntBits-1:0]  rd_q, rd_d;
  logic [CntBits-1:0]  keep_q, keep_d;
  logic [5:0]          woken_q, woken_d;
  logic [5:0]          limit_q;
  logic [31:0]         addr_q;
  logic [31:0]         ra_q;
  logic [TaskBits-1:0] rt_q;
  logic                rv_q;   // registered read entry present
  logic                we;
  logic [IdxBits-1:0]  wa;
  logic [31:0]         wdat_a;
  logic [TaskBits-1:0] wdat_t;
  logic                take;
  logic                out_v_d, out_tv_d, out_last_d;
  logic [2:0]          out_st_d;
  logic [7:0]          out_task_d;
  logic [5:0]          out_tot_d;
  logic                rd_more;

  assign rd_more = (rd_q < count_q);
  assign take    = rv_q && (woken_q < limit_q) && (ra_q == addr_q);

  always_comb begin
    st_d = st_q; count_d = count_q; rd_d = rd_q; keep_d = keep_q; woken_d = woken_q;
    pop_o = 1'b0; we = 1'b0; wa = '0; wdat_a = ra_q; wdat_t = rt_q;
    out_v_d = 1'b0; out_tv_d = 1'b0; out_last_d = 1'b0; out_st_d = StOk;
    out_task_d = '0; out_tot_d = '0;
    unique case (st_q)
      SIdle: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            CmdWait: begin
              out_v_d = 1'b1; out_last_d = 1'b1;
              if (count_q >= CntBits'(MaxWaiters)) out_st_d = StNoMem;
              else if (cmd_i.mem_val != cmd_i.arg) out_st_d = StAgain;
              else begin
                we = 1'b1; wa = count_q[IdxBits-1:0];
                wdat_a = cmd_i.addr; wdat_t = cmd_i.task_id;
                count_d = count_q + 1'b1;
              end
            end
            CmdWake: begin
              st_d = SRead; rd_d = '0; keep_d = '0; woken_d = '0;
            end
            default: begin
              out_v_d = 1'b1; out_last_d = 1'b1; out_st_d = cmd_i.status;
            end
          endcase
        end
      end
      SRead: begin
        st_d = SScan;
        if (rd_more) rd_d = rd_q + 1'b1;
      end
      SScan: begin
        if (rv_q) begin
          if (take) begin
            woken_d = woken_q + 1'b1;
            out_v_d = 1'b1; out_tv_d = 1'b1;
            out_task_d = 8'(rt_q); out_tot_d = woken_q + 1'b1;
          end else begin
            we = 1'b1; wa = keep_q[IdxBits-1:0];
            keep_d = keep_q + 1'b1;
          end
        end
        if (rd_more) rd_d = rd_q + 1'b1;
        if (!rv_q) begin
          // Table exhausted: finish the request.
          st_d = SIdle; count_d = keep_q;
          if (woken_q == '0) begin
            out_v_d = 1'b1; out_last_d = 1'b1;
          end
        end
      end
      default: st_d = SIdle;
    endcase
  end

  // Result register; each woken result is held until the next one or the end of the
  // scan, so that its last flag can be set once the rest are known not to match.
  logic               hold_v_q, hold_tv_q;
  logic [2:0]         hold_st_q;
  logic [7:0]         hold_task_q;
  logic [5:0]         hold_tot_q;
  logic               fin;

  assign fin = (st_q == SScan) && !rv_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      addr_mem[wa] <= wdat_a;
      task_mem[wa] <= wdat_t;
    end
    ra_q <= addr_mem[rd_q[IdxBits-1:0]];
    rt_q <= task_mem[rd_q[IdxBits-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; count_q <= '0; rd_q <= '0; keep_q <= '0; woken_q <= '0;
      limit_q <= '0; addr_q <= '0; rv_q <= 1'b0;
      hold_v_q <= 1'b0; hold_tv_q <= 1'b0;
      hold_st_q <= '0; hold_task_q <= '0; hold_tot_q <= '0;
      done_o <= 1'b0; status_o <= '0; task_valid_o <= 1'b0; woken_task_o <= '0;
      woken_total_o <= '0; last_o <= 1'b0;
    end else begin
      st_q <= st_d; count_q <= count_d; rd_q <= rd_d; keep_q <= keep_d;
      woken_q <= woken_d;
      if (st_q == SIdle && cmd_valid_i) begin
        limit_q <= cmd_i.limit; addr_q <= cmd_i.addr;
      end
      rv_q <= (st_q != SIdle) && (st_d != SIdle) && rd_more;
      done_o <= 1'b0; last_o <= 1'b0;
      if (out_v_d && out_tv_d) begin
        // A new woken result pushes out any held one.
        if (hold_v_q) begin
          done_o <= 1'b1; status_o <= hold_st_q; task_valid_o <= hold_tv_q;
          woken_task_o <= hold_task_q; woken_total_o <= hold_tot_q; last_o <= 1'b0;
        end
        hold_v_q <= 1'b1; hold_tv_q <= 1'b1; hold_st_q <= StOk;
        hold_task_q <= out_task_d; hold_tot_q <= out_tot_d;
      end else if (fin && hold_v_q) begin
        done_o <= 1'b1; status_o <= hold_st_q; task_valid_o <= 1'b1;
        woken_task_o <= hold_task_q; woken_total_o <= hold_tot_q; last_o <= 1'b1;
        hold_v_q <= 1'b0;
      end else if (out_v_d) begin
        done_o <= 1'b1; status_o <= out_st_d; task_valid_o <= 1'b0;
        woken_task_o <= '0; woken_total_o <= '0; last_o <= out_last_d;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(MaxWaiters)) else $error("waiter count overflow");
  a_woken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    woken_q <= limit_q || st_q == SIdle) else $error("woke past limit");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> st_q == SIdle) else $error("command taken while busy");
  a_scan_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SScan && st_d == SIdle) |=> count_q <= $past(count_q))
    else $error("wake grew the table");
`endif
endmodule

@@ rtl/futex_wait_queue_table.sv @@
// Top level of the futex wait queue table: front end, command queue and back
// end that holds the waiter table. Depends on fwq_pkg, fwq_front, fwq_back.
//
//  Channel   Direction  Handshake            Beat contents
//  request   in         start_i & !busy_o    opcode, address, fault, values, task
//  result    out        done_o (no stall)    status, task_valid, task, total, last
//
// A wait, an error or an empty wake yields its single result once it has passed
// through the command queue and the result register. A wake with a positive count
// scans the whole table, one entry a cycle through the registered read port, and
// its final beat, with last_o set, follows once all waiters held have been read.
// The front end queues up to two requests, so busy_o rises only when both slots
// hold commands the back end has not yet taken. Reset (rst_ni low) empties the
// table and the queue; no clearing pass is needed. Results cannot be stalled.
module futex_wait_queue_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [7:0]        opcode_i,
  input  logic [31:0]       word_address_i,
  input  logic              access_fault_i,
  input  logic signed [31:0] memory_value_i,
  input  logic signed [31:0] argument_i,
  input  logic [7:0]        task_id_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic              task_valid_o,
  output logic [7:0]        woken_task_o,
  output logic [5:0]        woken_total_o,
  output logic              last_o
);
  import fwq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic pop;

  fwq_front u_front (
    .clk_i, .rst_ni, .start_i, .opcode_i, .word_address_i, .access_fault_i,
    .memory_value_i, .argument_i, .task_id_i, .busy_o,
    .pop_i(pop), .cmd_valid_o(cmd_valid), .cmd_o(cmd)
  );

  fwq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .pop_o(pop),
    .done_o, .status_o, .task_valid_o, .woken_task_o, .woken_total_o, .last_o
  );
endmodule
